// ===== sv/dq_pkg.sv =====
// Shared definitions for the double-ended queue: command codes and status codes.
// Self-contained; the top level refers to it by scoped names.
`default_nettype none

package dq_pkg;

    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 9;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_PEEK_FRONT = 3'd4,
        FN_PEEK_BACK  = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ===== sv/dq_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module dq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of 32-bit words kept in a ring RAM.
// Depends on dq_pkg (codes) and dq_ram (word storage).
`default_nettype none

//  Channel   | Ports                          | Beat taken when
//  ----------+--------------------------------+------------------------------------
//  command   | start, busy, func, value       | rising edge with start=1, busy=0
//  result    | done, word, status, occupancy  | rising edge ending the done cycle
//
// Every command gives exactly one result beat, in the cycle after it is taken.
// The queue takes a command in every cycle: each command touches at most one
// RAM entry, and the result word comes from the single registered RAM read port.
// busy never rises, so commands are taken back to back at one beat per cycle.
// Reset clears the front pointer and the count; the RAM is not cleared, since
// only entries written by a push are ever read. The receiver cannot stall.

module double_ended_queue #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output      logic                         busy,
    input  wire logic [dq_pkg::FUNC_W-1:0]    func,
    input  wire logic signed [dq_pkg::WORD_W-1:0] value,
    output      logic                         done,
    output      logic signed [dq_pkg::WORD_W-1:0] word,
    output      logic [dq_pkg::STATUS_W-1:0]  status,
    output      logic [dq_pkg::OCC_W-1:0]     occupancy
);

    // Pointer width, count width (the count can equal DEPTH) and a sum width
    // wide enough for front pointer plus count.
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;

    logic                          done_reg;
    logic                          rd_reg;
    dq_pkg::status_t               status_reg, status_next;
    logic [dq_pkg::OCC_W-1:0]      occ_reg;

    logic accept;
    logic is_empty, is_full;

    // Back slot addresses: the slot just past the back, and the back word itself.
    logic [SW-1:0] back_sum, back_sum_m1;
    logic [AW-1:0] back_free, back_word, front_dec, front_inc;

    logic                           ram_we, ram_re;
    logic [AW-1:0]                  ram_waddr, ram_raddr;
    logic [dq_pkg::WORD_W-1:0]      ram_rdata;

    assign accept   = start && !busy;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_CNT);

    // Both sums stay below twice the depth, so one compare-and-subtract wraps them.
    always_comb
    begin
        back_sum    = SW'(front_reg) + SW'(count_reg);
        back_sum_m1 = back_sum - SW'(1);
        if (back_sum >= DEPTH_SUM)
        begin
            back_free = AW'(back_sum - DEPTH_SUM);
        end
        else
        begin
            back_free = AW'(back_sum);
        end
        if (back_sum_m1 >= DEPTH_SUM)
        begin
            back_word = AW'(back_sum_m1 - DEPTH_SUM);
        end
        else
        begin
            back_word = AW'(back_sum_m1);
        end
        front_dec = (front_reg == '0) ? LAST_IDX : front_reg - AW'(1);
        front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + AW'(1);
    end

    // Command decode. Writes go to the RAM at the accepting edge and reads are
    // launched at the same edge; a push and a read never happen together, and
    // a read in the following cycle already sees the completed write, so no
    // forwarding path is needed.
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = dq_pkg::ST_OK;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = back_free;
        ram_raddr   = front_reg;
        if (accept)
        begin
            unique case (func)
                dq_pkg::FN_PUSH_FRONT,
                dq_pkg::FN_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = dq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (func == dq_pkg::FN_PUSH_FRONT)
                        begin
                            front_next = front_dec;
                            ram_waddr  = front_dec;
                        end
                    end
                end
                dq_pkg::FN_POP_FRONT,
                dq_pkg::FN_POP_BACK,
                dq_pkg::FN_PEEK_FRONT,
                dq_pkg::FN_PEEK_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = dq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ram_re = 1'b1;
                        if (func == dq_pkg::FN_POP_BACK || func == dq_pkg::FN_PEEK_BACK)
                        begin
                            ram_raddr = back_word;
                        end
                        if (func == dq_pkg::FN_POP_FRONT)
                        begin
                            front_next = front_inc;
                            count_next = count_reg - CW'(1);
                        end
                        else if (func == dq_pkg::FN_POP_BACK)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                default:
                begin
                    // Unused codes change nothing and report ok.
                end
            endcase
        end
    end

    dq_ram #(
        .WIDTH (dq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            done_reg  <= accept;
            rd_reg    <= ram_re;
        end
    end

    // Result payload; the occupancy is the count after the command, cut to the port.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        occ_reg    <= dq_pkg::OCC_W'(count_next);
    end

    assign busy      = 1'b0;
    assign done      = done_reg;
    assign word      = rd_reg ? ram_rdata : '0;
    assign status    = status_reg;
    assign occupancy = occ_reg;

    // The count never exceeds the ring size and the front pointer stays in range.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= FULL_CNT))
        else $error("queue count above depth");

    a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
        (front_reg <= LAST_IDX))
        else $error("front pointer out of range");

    // Every taken command produces a result beat in the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("missing result beat");

    // A full rejection leaves the queue full; an empty report leaves it empty.
    a_full_stat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == dq_pkg::ST_FULL) |-> is_full)
        else $error("full status with room left");

    a_empty_stat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == dq_pkg::ST_EMPTY) |-> is_empty)
        else $error("empty status with words held");

endmodule

`default_nettype wire

// ===== verif/double_ended_queue_tb.sv =====
// Self-checking testbench for double_ended_queue: random and directed commands with a
// shadow deque that predicts every reply beat. Depends on dq_pkg and the RTL top level.

module double_ended_queue_tb;

    localparam int unsigned DEPTH       = 256;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_REPORTS = 10;

    // Codes 6 and 7 are not in func_t; the queue must answer them with an
    // ok status and leave its contents alone.
    localparam logic [dq_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [dq_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    // One command waiting in the driver's list. gap is the number of idle cycles
    // that follow its beat; settle holds the command back until every reply owed
    // so far has come in.
    typedef struct {
        logic [dq_pkg::FUNC_W-1:0] op;
        logic [dq_pkg::WORD_W-1:0] arg;
        int unsigned               gap;
        bit                        settle;
    } deque_cmd_t;

    typedef struct packed {
        logic [dq_pkg::WORD_W-1:0] word;
        dq_pkg::status_t           status;
        logic [dq_pkg::OCC_W-1:0]  occupancy;
    } deque_reply_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic [dq_pkg::FUNC_W-1:0]        func = '0;
    logic signed [dq_pkg::WORD_W-1:0] value = '0;
    logic                             busy;
    logic                             done;
    logic signed [dq_pkg::WORD_W-1:0] word;
    logic [dq_pkg::STATUS_W-1:0]      status;
    logic [dq_pkg::OCC_W-1:0]         occupancy;

    deque_cmd_t   cmd_list[$];
    deque_reply_t replies_due[$];
    int unsigned  results_owed = 0;
    int unsigned  gap_left = 0;
    int unsigned  reply_count = 0;
    int unsigned  fail_count = 0;
    int unsigned  cycle_count = 0;

    // Shadow copy of the deque. Entries are only read after a push has written
    // them, so the ring needs no clearing.
    logic [dq_pkg::WORD_W-1:0] shadow_ring[DEPTH];
    int unsigned               shadow_head = 0;
    int unsigned               shadow_count = 0;

    double_ended_queue #(.DEPTH(DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .value     (value),
        .done      (done),
        .word      (word),
        .status    (status),
        .occupancy (occupancy)
    );

    always #5 clk = ~clk;

    // Applies one command to the shadow deque and returns the reply it must give.
    function automatic deque_reply_t apply_to_shadow(input logic [dq_pkg::FUNC_W-1:0] op,
                                                     input logic [dq_pkg::WORD_W-1:0] arg);
        deque_reply_t r;
        int unsigned  slot;
        r.word   = '0;
        r.status = dq_pkg::ST_OK;
        case (op)
            dq_pkg::FN_PUSH_FRONT, dq_pkg::FN_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                    r.status = dq_pkg::ST_FULL;
                else
                begin
                    if (op == dq_pkg::FN_PUSH_FRONT)
                    begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        slot = shadow_head;
                    end
                    else
                        slot = (shadow_head + shadow_count) % DEPTH;
                    shadow_ring[slot] = arg;
                    shadow_count++;
                end
            end
            dq_pkg::FN_POP_FRONT, dq_pkg::FN_POP_BACK,
            dq_pkg::FN_PEEK_FRONT, dq_pkg::FN_PEEK_BACK:
            begin
                if (shadow_count == 0)
                    r.status = dq_pkg::ST_EMPTY;
                else
                begin
                    if (op == dq_pkg::FN_POP_FRONT || op == dq_pkg::FN_PEEK_FRONT)
                        slot = shadow_head;
                    else
                        slot = (shadow_head + shadow_count - 1) % DEPTH;
                    r.word = shadow_ring[slot];
                    if (op == dq_pkg::FN_POP_FRONT)
                    begin
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_count--;
                    end
                    else if (op == dq_pkg::FN_POP_BACK)
                        shadow_count--;
                end
            end
            default:
                ;
        endcase
        r.occupancy = dq_pkg::OCC_W'(shadow_count);
        return r;
    endfunction

    // Every failure goes through here; only the first MAX_REPORTS are printed.
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic void check_field(input string name,
                                        input logic [dq_pkg::WORD_W-1:0] want,
                                        input logic [dq_pkg::WORD_W-1:0] got);
        if (got !== want)
            note_failure($sformatf("reply beat %0d, %s: expected %h, got %h",
                                   reply_count, name, want, got));
    endfunction

    // Idle cycles after a beat: mostly none or a few, now and then a long pause.
    function automatic int unsigned pick_gap(input bit gapless);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (gapless || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Random words, with the corner values mixed in so they show up at both ends.
    function automatic logic [dq_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_cmd(input logic [dq_pkg::FUNC_W-1:0] op,
                           input logic [dq_pkg::WORD_W-1:0] arg,
                           input int unsigned gap, input bit settle);
        deque_cmd_t c;
        c.op     = op;
        c.arg    = arg;
        c.gap    = gap;
        c.settle = settle;
        cmd_list.push_back(c);
    endtask

    // Driver. A command is shown on the ports until it is taken, then the next one
    // is pulled from the list after its idle gap. Each port gets one nonblocking
    // update per edge, so start stays high across back-to-back beats.
    always @(posedge clk or negedge rst_n)
    begin
        deque_cmd_t nxt;
        if (!rst_n)
        begin
            start    <= 1'b0;
            func     <= '0;
            value    <= '0;
            gap_left <= 0;
        end
        else if (!start || !busy)
        begin
            if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cmd_list.size() != 0 &&
                     !(cmd_list[0].settle && (start || results_owed != 0)))
            begin
                nxt = cmd_list.pop_front();
                start    <= 1'b1;
                func     <= nxt.op;
                value    <= nxt.arg;
                gap_left <= nxt.gap;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor. Replies are checked against the oldest prediction first; then a
    // command taken at this edge is run through the shadow deque. results_owed
    // tells the driver and the end of the run how many replies are still due.
    always @(posedge clk)
    begin
        deque_reply_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (replies_due.size() == 0)
                    note_failure($sformatf("reply beat %0d arrived with none due: %h %0d %0d",
                                           reply_count, word, status, occupancy));
                else
                begin
                    want = replies_due.pop_front();
                    check_field("word", want.word, word);
                    check_field("status", dq_pkg::WORD_W'(want.status),
                                dq_pkg::WORD_W'(status));
                    check_field("occupancy", dq_pkg::WORD_W'(want.occupancy),
                                dq_pkg::WORD_W'(occupancy));
                end
                reply_count++;
            end
            if (start && !busy)
                replies_due.push_back(apply_to_shadow(func, value));
            results_owed <= replies_due.size();
        end
    end

    // Watchdog for a queue that stops answering or never takes a command.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase_len[5];
        int unsigned push_pct[5];
        bit          phase_gapless[5];
        bit          phase_settle[5];
        int unsigned roll;
        logic [dq_pkg::FUNC_W-1:0] op;

        // Directed opening: every take on an empty queue, the two spare codes,
        // the corner words pushed at both ends and read back from both ends, and
        // a pop that empties the queue followed by one more pop.
        add_cmd(dq_pkg::FN_POP_FRONT,  32'h1234_5678, 0, 0);
        add_cmd(dq_pkg::FN_POP_BACK,   32'h0,         0, 0);
        add_cmd(dq_pkg::FN_PEEK_FRONT, 32'h0,         1, 0);
        add_cmd(dq_pkg::FN_PEEK_BACK,  32'h0,         0, 0);
        add_cmd(FN_SPARE_LO,           32'hDEAD_BEEF, 0, 0);
        add_cmd(FN_SPARE_HI,           32'h0,         2, 0);
        add_cmd(dq_pkg::FN_PUSH_BACK,  32'h7FFF_FFFF, 0, 0);
        add_cmd(dq_pkg::FN_PUSH_FRONT, 32'h8000_0000, 0, 0);
        add_cmd(dq_pkg::FN_PUSH_BACK,  32'h0000_0000, 0, 0);
        add_cmd(dq_pkg::FN_PUSH_FRONT, 32'hFFFF_FFFF, 0, 0);
        add_cmd(dq_pkg::FN_PEEK_FRONT, 32'h0,         0, 0);
        add_cmd(dq_pkg::FN_PEEK_BACK,  32'h0,         3, 0);
        add_cmd(FN_SPARE_LO,           32'hFFFF_FFFF, 0, 0);
        add_cmd(FN_SPARE_HI,           32'h5555_5555, 0, 0);
        add_cmd(dq_pkg::FN_POP_BACK,   32'h0,         0, 0);
        add_cmd(dq_pkg::FN_POP_FRONT,  32'h0,         0, 0);
        add_cmd(dq_pkg::FN_POP_BACK,   32'h0,         1, 0);
        add_cmd(dq_pkg::FN_PEEK_FRONT, 32'h0,         0, 0);
        add_cmd(dq_pkg::FN_POP_FRONT,  32'h0,         0, 0);
        add_cmd(dq_pkg::FN_POP_BACK,   32'h0,         0, 0);
        add_cmd(dq_pkg::FN_PUSH_FRONT, 32'hA5A5_A5A5, 0, 0);
        add_cmd(dq_pkg::FN_POP_BACK,   32'h0,         0, 0);
        add_cmd(dq_pkg::FN_PUSH_BACK,  32'h5A5A_5A5A, 0, 0);
        add_cmd(dq_pkg::FN_POP_FRONT,  32'h0,         0, 0);

        // Random part in phases. The fill phase drives the queue to full and keeps
        // knocking on it, the drain phase takes it back down past empty, and the
        // mixed phases wander around the middle while the pointers wrap. Two
        // phases run without any idle cycles; two start only after the queue has
        // answered everything sent before them.
        phase_len     = '{150, 320, 60, 380, 140};
        push_pct      = '{55, 92, 70, 4, 50};
        phase_gapless = '{0, 0, 1, 0, 1};
        phase_settle  = '{1, 0, 0, 1, 0};
        for (int p = 0; p < 5; p++)
        begin
            for (int unsigned n = 0; n < phase_len[p]; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    op = $urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO;
                else if ($urandom_range(0, 99) < push_pct[p])
                    op = $urandom_range(0, 1) ? dq_pkg::FN_PUSH_BACK
                                              : dq_pkg::FN_PUSH_FRONT;
                else if ($urandom_range(0, 99) < 80)
                    op = $urandom_range(0, 1) ? dq_pkg::FN_POP_BACK
                                              : dq_pkg::FN_POP_FRONT;
                else
                    op = $urandom_range(0, 1) ? dq_pkg::FN_PEEK_BACK
                                              : dq_pkg::FN_PEEK_FRONT;
                add_cmd(op, pick_word(), pick_gap(phase_gapless[p]),
                        phase_settle[p] && n == 0);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Sampling at the falling edge keeps this clear of the updates made by the
        // driver and the monitor at the rising edge.
        do
            @(negedge clk);
        while (cmd_list.size() != 0 || start || results_owed != 0);

        // The reply comes in the cycle after its command is taken; the extra wait here
        // catches any stray reply beat.
        repeat (8) @(negedge clk);
        if (replies_due.size() != 0)
            note_failure($sformatf("%0d reply beats never arrived", replies_due.size()));

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dq_pkg.sv
sv/dq_ram.sv
sv/double_ended_queue.sv
verif/double_ended_queue_tb.sv
